/* design/bba_pkg.sv */
// package for the buddy block allocator: beat types and shared constants
`default_nettype none
package bba_pkg;
    localparam int unsigned OffsetWidth = 10;
    localparam int unsigned SizeWidth   = 32;
    localparam int unsigned OrderWidth  = 6;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        logic                   action;
        logic [SizeWidth-1:0]   request_size;
        logic [OffsetWidth-1:0] block_offset;
    } t_req;

    typedef struct packed {
        logic                   ok;
        logic [OffsetWidth-1:0] granted_offset;
        logic [OrderWidth-1:0]  granted_order;
    } t_rsp;
endpackage
`default_nettype wire

/* design/bba_order_calc.sv */
// iterative ceil(log2) of a request size, one bit per cycle
`default_nettype none
module bba_order_calc (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_go,
    input  wire logic [bba_pkg::SizeWidth-1:0]  i_size,
    output logic                                o_done,
    output logic [bba_pkg::OrderWidth-1:0]      o_order
);
    logic [bba_pkg::SizeWidth-1:0]  r_val, n_val;
    logic [bba_pkg::OrderWidth-1:0] r_cnt, n_cnt;
    logic                           r_run, n_run;
    logic                           r_done, n_done;

    always_comb begin
        n_val  = r_val;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_go) begin
            n_val = (i_size <= bba_pkg::SizeWidth'(1)) ? '0 : i_size - bba_pkg::SizeWidth'(1);
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (r_val == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end else begin
                n_val = r_val >> 1;
                n_cnt = r_cnt + bba_pkg::OrderWidth'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_val <= n_val;
        r_cnt <= n_cnt;
    end

    assign o_done  = r_done;
    assign o_order = r_cnt;
endmodule
`default_nettype wire

/* design/buddy_block_allocator_unit.sv */
// top level of the buddy block allocator: sequencer and free list memory
//
// usage: one request beat is taken when i_start is high and o_busy is low.
// the beat carries an action (allocate or free), a byte size and, for a
// free, the block offset. exactly one result beat follows, shown for one
// cycle with o_strobe high; the receiver cannot stall it.
// sequence: the order of the size is found one bit a cycle. an allocate
// then scans the order counts one order a cycle, reads the head of the
// found list, shifts that list down one entry at a time (read, then
// write), and appends one upper half a cycle while splitting. a free
// scans the list of its order one entry at a time (step, memory read,
// compare), removes a match by shifting, and repeats one order higher.
// the cost is bounded by the list walks through the one-read, one-write
// free list memory, and in the worst case is proportional to the list lengths.
// busy stays high from the accepted beat until the result beat.
// reset: the counts reset at once (top order one, others zero) and the
// top list's first entry is written as offset zero in the init state,
// during which busy is held high; no other clearing pass is needed.
`default_nettype none
module buddy_block_allocator_unit #(
    parameter int unsigned POOL_ORDER = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire bba_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_strobe,
    output bba_pkg::t_rsp      o_rsp
);
    localparam int unsigned NumOrders = POOL_ORDER + 1;
    localparam int unsigned Space     = 2 << POOL_ORDER;
    localparam int unsigned AW        = $clog2(Space);
    localparam int unsigned CW        = POOL_ORDER + 1;
    localparam int unsigned KW        = $clog2(NumOrders + 1);
    localparam int unsigned PW        = POOL_ORDER;

    typedef enum logic [14:0] {
        S_INIT   = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_ORD    = 15'b000000000000100,
        S_ASCAN  = 15'b000000000001000,
        S_AHEAD  = 15'b000000000010000,
        S_AHWAIT = 15'b000000000100000,
        S_SHRD   = 15'b000000001000000,
        S_SHWR   = 15'b000000010000000,
        S_SPLIT  = 15'b000000100000000,
        S_FSTEP  = 15'b000001000000000,
        S_FRD    = 15'b000010000000000,
        S_FCMP   = 15'b000100000000000,
        S_FAPP   = 15'b001000000000000,
        S_DONE   = 15'b010000000000000,
        S_FAIL   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // free list memory, reset value undefined except top head
    logic [PW-1:0] mem [Space];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [PW-1:0] mem_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    logic [CW-1:0] r_cnt [NumOrders];
    logic [CW-1:0] n_cnt [NumOrders];

    logic [KW-1:0]  r_k, n_k;
    logic [KW-1:0]  r_ord, n_ord;
    logic [CW-1:0]  r_p, n_p;
    logic [PW-1:0]  r_addr, n_addr;
    logic [PW-1:0]  r_off, n_off;
    logic           r_act, n_act;
    logic           r_strobe, n_strobe;
    bba_pkg::t_rsp  r_rsp, n_rsp;
    logic [bba_pkg::OrderWidth-1:0] r_ordfull, n_ordfull;

    logic                           oc_go, oc_done;
    logic [bba_pkg::OrderWidth-1:0] oc_order;

    bba_order_calc u_ord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (oc_go),
        .i_size  (i_req.request_size),
        .o_done  (oc_done),
        .o_order (oc_order)
    );

    function automatic logic [AW-1:0] base_of(input logic [KW-1:0] k);
        logic [AW:0] full;
        logic [AW:0] part;
        full = (AW+1)'(Space);
        part = (AW+1)'(2) << (KW'(POOL_ORDER) - k);
        return AW'(full - part);
    endfunction

    function automatic logic [CW-1:0] cap_of(input logic [KW-1:0] k);
        return CW'(1) << (KW'(POOL_ORDER) - k);
    endfunction

    logic [CW-1:0] cur_cnt;
    logic [PW-1:0] mask;
    assign cur_cnt = r_cnt[r_k[$clog2(NumOrders)-1:0]];
    assign mask    = ~((PW'(2) << r_k) - PW'(1));

    logic accept;
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_ord     = r_ord;
        n_p       = r_p;
        n_addr    = r_addr;
        n_off     = r_off;
        n_act     = r_act;
        n_strobe  = 1'b0;
        n_rsp     = r_rsp;
        n_ordfull = r_ordfull;
        for (int i = 0; i < NumOrders; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        mem_we    = 1'b0;
        mem_waddr = base_of(KW'(POOL_ORDER));
        mem_wdata = '0;
        mem_raddr = base_of(r_k) + AW'(r_p);
        oc_go     = 1'b0;
        unique case (r_state)
            S_INIT: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    oc_go   = 1'b1;
                    n_act   = i_req.action;
                    // keep the low pool-order bits of the offset
                    n_addr  = PW'(i_req.block_offset);
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                if (oc_done) begin
                    n_ordfull = oc_order;
                    n_ord     = KW'(oc_order);
                    n_k       = KW'(oc_order);
                    n_p       = '0;
                    if (oc_order > bba_pkg::OrderWidth'(POOL_ORDER)) begin
                        n_state = S_FAIL;
                    end else if (r_act == bba_pkg::ACT_ALLOC) begin
                        n_state = S_ASCAN;
                    end else begin
                        n_state = S_FSTEP;
                    end
                end
            end
            S_ASCAN: begin
                if (r_k > KW'(POOL_ORDER)) begin
                    n_state = S_FAIL;
                end else if (cur_cnt == '0) begin
                    n_k = r_k + KW'(1);
                end else begin
                    n_p     = '0;
                    n_state = S_AHEAD;
                end
            end
            S_AHEAD: begin
                n_state = S_AHWAIT;
            end
            S_AHWAIT: begin
                n_off   = r_rdata;
                n_p     = CW'(1);
                n_state = S_SHRD;
            end
            S_SHRD: begin
                // shift the list down: read entry p
                if (r_p >= cur_cnt) begin
                    n_cnt[r_k[$clog2(NumOrders)-1:0]] = cur_cnt - CW'(1);
                    n_state = (r_act == bba_pkg::ACT_ALLOC) ? S_SPLIT : S_FSTEP;
                    if (r_act != bba_pkg::ACT_ALLOC) begin
                        n_k = r_k + KW'(1);
                        n_p = '0;
                    end
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_waddr = base_of(r_k) + AW'(r_p) - AW'(1);
                mem_wdata = r_rdata;
                n_p       = r_p + CW'(1);
                n_state   = S_SHRD;
            end
            S_SPLIT: begin
                if (r_k > r_ord) begin
                    logic [KW-1:0] j;
                    logic [CW-1:0] c;
                    j = r_k - KW'(1);
                    c = r_cnt[j[$clog2(NumOrders)-1:0]];
                    if (c < cap_of(j)) begin
                        mem_we    = 1'b1;
                        mem_waddr = base_of(j) + AW'(c);
                        mem_wdata = r_off + (PW'(1) << j);
                        n_cnt[j[$clog2(NumOrders)-1:0]] = c + CW'(1);
                    end
                    n_k = j;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FSTEP: begin
                n_addr = r_addr;
                if (r_k >= KW'(POOL_ORDER)) begin
                    n_k     = KW'(POOL_ORDER);
                    n_state = S_FAPP;
                end else if (r_p >= cur_cnt) begin
                    n_state = S_FAPP;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_FCMP;
            end
            S_FCMP: begin
                if ((r_rdata & mask) == (r_addr & mask)) begin
                    n_addr  = r_addr & mask;
                    n_p     = r_p + CW'(1);
                    n_state = S_SHRD;
                end else begin
                    n_p     = r_p + CW'(1);
                    n_state = S_FSTEP;
                end
            end
            S_FAPP: begin
                if (cur_cnt < cap_of(r_k)) begin
                    mem_we    = 1'b1;
                    mem_waddr = base_of(r_k) + AW'(cur_cnt);
                    mem_wdata = r_addr;
                    n_cnt[r_k[$clog2(NumOrders)-1:0]] = cur_cnt + CW'(1);
                end
                n_off   = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_strobe             = 1'b1;
                n_rsp.ok             = 1'b1;
                n_rsp.granted_offset = bba_pkg::OffsetWidth'(r_off);
                n_rsp.granted_order  = r_ordfull;
                n_state              = S_IDLE;
            end
            S_FAIL: begin
                n_strobe             = 1'b1;
                n_rsp.ok             = 1'b0;
                n_rsp.granted_offset = '0;
                n_rsp.granted_order  = r_ordfull;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_strobe <= 1'b0;
            for (int i = 0; i < NumOrders; i++) begin
                r_cnt[i] <= (i == POOL_ORDER) ? CW'(1) : '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            for (int i = 0; i < NumOrders; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
        r_k       <= n_k;
        r_ord     <= n_ord;
        r_p       <= n_p;
        r_addr    <= n_addr;
        r_off     <= n_off;
        r_act     <= n_act;
        r_rsp     <= n_rsp;
        r_ordfull <= n_ordfull;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result beat outside idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("busy not raised after accept");
    a_top_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[POOL_ORDER] <= CW'(1))
        else $error("top list overfull");
`endif
endmodule
`default_nettype wire
